@@ hdl/disjoint_range_table_core_macros.svh @@
// assertion helpers for the range table
`ifndef DISJOINT_RANGE_TABLE_CORE_MACROS_SVH
`define DISJOINT_RANGE_TABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define DRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range table check failed");
`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range table sequence check failed");
`else
`define DRT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/drt_pkg.sv @@
`default_nettype none
package drt_pkg;
  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_BITS     = 32;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_REM_EXACT = 3'd1,
    CMD_REM_ADDR  = 3'd2,
    CMD_LOOKUP    = 3'd3,
    CMD_NEIGHBOR  = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERLAP   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;

  // broadcast request, addresses zero-extended to the widest setting
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] start;
    logic [63:0] len;
    logic [63:0] last;
    logic [63:0] probe;
  } req_t;

  // partial scan result passed from cell to cell
  typedef struct packed {
    logic [8:0]  count;
    logic        overlap;
    logic        free_found;
    logic [7:0]  free_idx;
    logic        match_found;
    logic [7:0]  match_idx;
    logic        sel_found;
    logic        sel_hit;
    logic [63:0] sel_start;
    logic [63:0] sel_len;
    logic [31:0] sel_tag;
    logic        above_found;
    logic [63:0] above_start;
  } carry_t;

  typedef struct packed {
    logic        set;
    logic        kill;
    logic        clr_all;
    logic [7:0]  idx;
    logic [63:0] start;
    logic [63:0] len;
    logic [31:0] tag;
  } wr_t;
endpackage
`default_nettype wire

@@ hdl/drt_cell.sv @@
`default_nettype none
module drt_cell #(
  parameter int IDX       = 0,
  parameter int ADDR_BITS = drt_pkg::ADDR_BITS
) (
  input  wire           clk,
  input  wire           rst,
  input  drt_pkg::req_t req,
  input  drt_pkg::wr_t  wr,
  input  drt_pkg::carry_t cin,
  output drt_pkg::carry_t cout
);
  logic                 valid;
  logic [ADDR_BITS-1:0] start;
  logic [ADDR_BITS-1:0] len;
  logic [31:0]          tag;

  logic [63:0] es, el, elast;
  logic        cont, mine;
  drt_pkg::carry_t cout_next;

  assign es    = 64'(start);
  assign el    = 64'(len);
  assign elast = es + el - 64'd1;
  assign cont  = valid && (req.probe >= es) && ((req.probe - es) < el);
  assign mine  = (wr.idx == 8'(IDX));

  always_comb begin
    cout_next = cin;
    if (valid) begin
      cout_next.count = cin.count + 9'd1;
      if (es <= req.last && req.start <= elast) cout_next.overlap = 1'b1;
    end else if (!cin.free_found) begin
      cout_next.free_found = 1'b1;
      cout_next.free_idx   = 8'(IDX);
    end
    case (req.cmd)
      drt_pkg::CMD_REM_EXACT: begin
        if (valid && es == req.start && el == req.len && !cin.match_found) begin
          cout_next.match_found = 1'b1;
          cout_next.match_idx   = 8'(IDX);
        end
      end
      drt_pkg::CMD_REM_ADDR: begin
        if (cont && !cin.match_found) begin
          cout_next.match_found = 1'b1;
          cout_next.match_idx   = 8'(IDX);
        end
      end
      drt_pkg::CMD_LOOKUP: begin
        if (cont && !cin.sel_found) begin
          cout_next.sel_found = 1'b1;
          cout_next.sel_hit   = 1'b1;
          cout_next.sel_start = es;
          cout_next.sel_len   = el;
          cout_next.sel_tag   = tag;
        end
      end
      drt_pkg::CMD_NEIGHBOR: begin
        if (valid && es <= req.probe) begin
          if (!cin.sel_found || es > cin.sel_start) begin
            cout_next.sel_found = 1'b1;
            cout_next.sel_hit   = cont;
            cout_next.sel_start = es;
            cout_next.sel_len   = el;
            cout_next.sel_tag   = tag;
          end
        end else if (valid) begin
          if (!cin.above_found || es < cin.above_start) begin
            cout_next.above_found = 1'b1;
            cout_next.above_start = es;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cout <= cout_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.clr_all) begin
      valid <= 1'b0;
    end else if (wr.set && mine) begin
      valid <= 1'b1;
    end else if (wr.kill && mine) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set && mine) begin
      start <= ADDR_BITS'(wr.start);
      len   <= ADDR_BITS'(wr.len);
      tag   <= wr.tag;
    end
  end
endmodule
`default_nettype wire

@@ hdl/disjoint_range_table_core.sv @@
// a command is registered on accept, the scan walks the cell chain one cell per cycle,
//   then the write-back state loads the result register and applies any table write
// a new command is accepted only in the idle state, after the write-back is done
// a stalled m_tready holds the write-back state
// reset: rst clears all valid bits and the control state; the table is empty
//   and ready for a command in the cycle after rst falls
`default_nettype none
`include "disjoint_range_table_core_macros.svh"
module disjoint_range_table_core #(
  parameter int TABLE_ENTRIES = drt_pkg::TABLE_ENTRIES,
  parameter int ADDR_BITS     = drt_pkg::ADDR_BITS
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // cmd[2:0] range_start[34:3] range_length[66:35] range_tag[98:67]
  // probe_address[130:99], zero pad above
  input  wire  [135:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // status[2:0] hit[3] hit_start[35:4] hit_length[67:36] hit_tag[99:68]
  // below_valid[100] above_valid[101] above_start[133:102]
  // entry_count[138:134], zero pad above
  output logic [143:0] m_tdata
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_CELL = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [IW-1:0] scan_cnt;
  drt_pkg::req_t req;
  logic [31:0]   req_tag;
  logic          req_bad;
  logic [CW-1:0] count_q;

  // incoming fields, reduced to the address width
  logic [ADDR_BITS-1:0] in_start, in_len;
  logic [ADDR_BITS:0]   in_sum;
  logic                 accept, out_load;

  drt_pkg::carry_t chain [0:TABLE_ENTRIES];
  drt_pkg::carry_t fin;
  drt_pkg::wr_t    wr;

  logic [2:0]  res_status;
  logic        res_hit, res_below, res_above;
  logic [31:0] res_start, res_len, res_tag, res_above_start;
  logic [8:0]  res_count;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_WRITE) && (!m_tvalid || m_tready);

  assign in_start = ADDR_BITS'(s_tdata[34:3]);
  assign in_len   = ADDR_BITS'(s_tdata[66:35]);
  assign in_sum   = {1'b0, in_start} + {1'b0, in_len};

  always_ff @(posedge clk) begin
    if (accept) begin
      req.cmd   <= s_tdata[2:0];
      req.start <= 64'(in_start);
      req.len   <= 64'(in_len);
      req.last  <= 64'(in_sum[ADDR_BITS-1:0] - ADDR_BITS'(1));
      req.probe <= 64'(ADDR_BITS'(s_tdata[130:99]));
      req_tag   <= s_tdata[98:67];
      // zero length, or last address beyond the top of the space
      req_bad   <= (in_len == '0) || (in_sum[ADDR_BITS] && in_sum[ADDR_BITS-1:0] != '0);
    end
  end

  // chain head starts with an empty partial result
  assign chain[0] = '0;
  assign fin      = chain[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    drt_cell #(
      .IDX       (g),
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .req  (req),
      .wr   (wr),
      .cin  (chain[g]),
      .cout (chain[g+1])
    );
  end

  // final decode of the scan result and the write-back it causes
  always_comb begin
    wr              = '0;
    wr.idx          = fin.free_idx;
    wr.start        = req.start;
    wr.len          = req.len;
    wr.tag          = req_tag;
    res_status      = drt_pkg::ST_OK;
    res_hit         = 1'b0;
    res_below       = 1'b0;
    res_above       = 1'b0;
    res_start       = '0;
    res_len         = '0;
    res_tag         = '0;
    res_above_start = '0;
    res_count       = fin.count;
    case (req.cmd)
      drt_pkg::CMD_INSERT: begin
        if (req_bad) begin
          res_status = drt_pkg::ST_BAD_SIZE;
        end else if (fin.overlap) begin
          res_status = drt_pkg::ST_OVERLAP;
        end else if (!fin.free_found) begin
          res_status = drt_pkg::ST_FULL;
        end else begin
          wr.set    = out_load;
          res_count = fin.count + 9'd1;
        end
      end
      drt_pkg::CMD_REM_EXACT, drt_pkg::CMD_REM_ADDR: begin
        wr.idx = fin.match_idx;
        if (fin.match_found) begin
          wr.kill   = out_load;
          res_count = fin.count - 9'd1;
        end else begin
          res_status = drt_pkg::ST_NOT_FOUND;
        end
      end
      drt_pkg::CMD_LOOKUP: begin
        if (fin.sel_found) begin
          res_hit   = 1'b1;
          res_start = 32'(fin.sel_start);
          res_len   = 32'(fin.sel_len);
          res_tag   = fin.sel_tag;
        end else begin
          res_status = drt_pkg::ST_NOT_FOUND;
        end
      end
      drt_pkg::CMD_NEIGHBOR: begin
        if (!fin.sel_found && !fin.above_found) res_status = drt_pkg::ST_NOT_FOUND;
        if (fin.sel_found) begin
          res_hit   = fin.sel_hit;
          res_start = 32'(fin.sel_start);
          res_len   = 32'(fin.sel_len);
          res_tag   = fin.sel_tag;
          res_below = 1'b1;
        end
        if (fin.above_found) begin
          res_above       = 1'b1;
          res_above_start = 32'(fin.above_start);
        end
      end
      drt_pkg::CMD_CLEAR: begin
        wr.clr_all = out_load;
        res_count  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (scan_cnt == LAST_CELL) state_next = S_WRITE;
      S_WRITE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
      m_tvalid <= 1'b0;
      count_q  <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= (scan_cnt == LAST_CELL) ? '0 : scan_cnt + IW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        count_q  <= CW'(res_count);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, 5'(res_count), res_above_start, res_above, res_below,
                  res_tag, res_len, res_start, res_hit, res_status};
    end
  end

  `DRT_ASSERT_NEXT(a_accept_scans, clk, rst, accept, state == S_SCAN)
  `DRT_ASSERT_NEXT(a_scan_ends, clk, rst, state == S_SCAN && scan_cnt == LAST_CELL,
    state == S_WRITE)
  `DRT_ASSERT_NEXT(a_write_shows, clk, rst, out_load, m_tvalid && state == S_IDLE)
  `DRT_ASSERT_IMPL(a_count_range, clk, rst, m_tvalid, count_q <= CW'(TABLE_ENTRIES))
endmodule
`default_nettype wire
